### rtl/core/dcic_pkg.sv
package dcic_pkg;

  // Field widths
  localparam int unsigned CountW  = 16;
  localparam int unsigned TickW   = 32;
  localparam int unsigned TargetW = 5;
  localparam int unsigned WrapW   = 4;
  localparam int unsigned UsW     = 32;
  localparam int unsigned XW      = 30;  // counts * 838 + 500 stays below 2^30
  localparam int unsigned FineW   = 21;  // quotient bits kept after the reciprocal
  localparam int unsigned ProdW   = 61;

  // Limits and scale factors
  localparam logic [CountW-1:0]  WRAP_LO           = 16'h4000;
  localparam logic [CountW-1:0]  WRAP_HI           = 16'hC000;
  localparam logic [WrapW-1:0]   MAX_WRAPS         = 4'd8;
  localparam logic [TargetW-1:0] TARGET_RESET      = 5'd4;
  localparam logic [9:0]         FINE_NS_PER_COUNT = 10'd838;
  localparam logic [8:0]         FINE_ROUND        = 9'd500;
  localparam logic [15:0]        US_PER_TICK       = 16'd54925;
  // ceil(2^40 / 1000): exact floor(x / 1000) for any x below 2^30
  localparam logic [30:0]        RECIP_1000        = 31'd1099511628;
  localparam int unsigned        RECIP_SHIFT       = 40;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_POLL  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_RUNNING = 2'd0,
    ST_OK      = 2'd1,
    ST_FAILED  = 2'd2,
    ST_IDLE    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    K_RUNNING = 2'd0,
    K_IDLE    = 2'd1,
    K_FAIL    = 2'd2,
    K_FINAL   = 2'd3
  } kind_e;

  // Classified request handed from front to back
  typedef struct packed {
    kind_e             kind;
    logic [TickW-1:0]  elapsed;
    logic [WrapW-1:0]  wraps;
    logic [CountW-1:0] sub;
  } req_t;

endpackage

### rtl/core/dual_clock_interval_checker_unit.sv
// Cross-checks a 16-bit down-counter (838 ns per count) against a 32-bit coarse tick
// (54925 us per tick). A start request arms the unit with the initial count and the
// reference tick; each poll request updates the wrap count and, once the elapsed ticks
// reach the configured tick target (0 acts as 1), runs the final check and answers ok
// or failed.
// Every request gets exactly one answer: status 0 running, 1 ok, 2 failed, 3 not armed;
// fine_us and coarse_us are nonzero only with ok. One request per cycle is sustained
// while the output is not stalled; an answer passes through the request queue and
// the two multiplier stages of the back end, then the output register. Write
// the tick target only while no request is in flight.
module dual_clock_interval_checker_unit import dcic_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [TargetW-1:0] cfg_wdata_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [63:0]        s_axis_tdata,  // counter_sample, verify_sample, tick_count
  input  logic [0:0]         s_axis_tuser,  // command
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [63:0]        m_axis_tdata,  // fine_us, coarse_us
  output logic [1:0]         m_axis_tuser   // status
);

  logic    full, empty, push, pop;
  req_t    req, head;
  status_e status;
  logic [UsW-1:0] fine_us, coarse_us;

  dcic_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .command_i   (s_axis_tuser[0]),
    .counter_i   (s_axis_tdata[15:0]),
    .verify_i    (s_axis_tdata[31:16]),
    .tick_i      (s_axis_tdata[63:32]),
    .full_i      (full),
    .push_o      (push),
    .req_o       (req)
  );

  dcic_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .req_i   (req),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  dcic_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_o    (status),
    .fine_o      (fine_us),
    .coarse_o    (coarse_us)
  );

  assign m_axis_tdata = {coarse_us, fine_us};
  assign m_axis_tuser = status;

endmodule

### rtl/core/dcic_front.sv
module dcic_front import dcic_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [TargetW-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic [CountW-1:0]  counter_i,
  input  logic [CountW-1:0]  verify_i,
  input  logic [TickW-1:0]   tick_i,
  input  logic               full_i,
  output logic               push_o,
  output req_t               req_o
);

  logic               armed_q, armed_d;
  logic [WrapW-1:0]   wraps_q, wraps_d;
  logic [TargetW-1:0] target_q;
  logic [CountW-1:0]  init_q, init_d;
  logic [CountW-1:0]  prev_q, prev_d;
  logic [TickW-1:0]   ref_q, ref_d;

  logic [TargetW-1:0] tgt;
  logic               wrap_hit;
  logic [WrapW-1:0]   wnext;
  logic [CountW-1:0]  prev_next;
  logic [TickW-1:0]   elapsed;
  logic               early_fail;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  assign tgt = (target_q == '0) ? TargetW'(1) : target_q;

  // upward step is a wrap only if it looks like a reload
  assign wrap_hit = (counter_i > prev_q) && (prev_q < WRAP_LO) &&
                    (counter_i > WRAP_HI) && (verify_i <= counter_i);
  assign wnext    = wraps_q + WrapW'(wrap_hit);

  always_comb begin
    if (wrap_hit) begin
      prev_next = verify_i;
    end else if (counter_i <= prev_q) begin
      prev_next = counter_i;
    end else begin
      prev_next = prev_q;  // phantom jump
    end
  end

  assign elapsed    = tick_i - ref_q;
  assign early_fail = (TargetW'(wnext) > tgt) || ((TargetW'(wnext) + TargetW'(1)) < tgt);

  always_comb begin
    armed_d = armed_q;
    wraps_d = wraps_q;
    init_d  = init_q;
    prev_d  = prev_q;
    ref_d   = ref_q;
    req_o.kind    = K_RUNNING;
    req_o.elapsed = elapsed;
    // extra wrap when the final count sits above the start value
    req_o.wraps   = wnext + WrapW'(prev_next > init_q);
    req_o.sub     = init_q - prev_next;
    if (push_o) begin
      if (command_i == CMD_START) begin
        armed_d = 1'b1;
        wraps_d = '0;
        init_d  = counter_i;
        prev_d  = counter_i;
        ref_d   = tick_i;
      end else if (!armed_q) begin
        req_o.kind = K_IDLE;
      end else if (wrap_hit && (wnext > MAX_WRAPS)) begin
        armed_d    = 1'b0;
        wraps_d    = wnext;
        req_o.kind = K_FAIL;
      end else begin
        prev_d  = prev_next;
        wraps_d = wnext;
        if (elapsed >= TickW'(tgt)) begin
          armed_d    = 1'b0;
          req_o.kind = early_fail ? K_FAIL : K_FINAL;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      wraps_q <= '0;
    end else begin
      armed_q <= armed_d;
      wraps_q <= wraps_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TARGET_RESET;
    end else if (cfg_we_i) begin
      target_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    init_q <= init_d;
    prev_q <= prev_d;
    ref_q  <= ref_d;
  end

endmodule

### rtl/core/dcic_queue.sv
module dcic_queue import dcic_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t req_i,
  input  logic pop_i,
  output logic full_o,
  output logic empty_o,
  output req_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  req_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= req_i;
    end
  end

endmodule

### rtl/core/dcic_back.sv
module dcic_back import dcic_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  req_t           head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output status_e        status_o,
  output logic [UsW-1:0] fine_o,
  output logic [UsW-1:0] coarse_o
);

  logic adv;

  // stage 1: counts * 838 + 500, ticks * 54925
  logic              s1_v_q;
  kind_e             s1_kind_q;
  logic [XW-1:0]     s1_x_q, x_d;
  logic [UsW-1:0]    s1_c_q;
  logic [19:0]       counts;
  logic [47:0]       cprod;

  // stage 2: reciprocal multiply for / 1000
  logic              s2_v_q;
  kind_e             s2_kind_q;
  logic [ProdW-1:0]  s2_f_q, fprod;
  logic [UsW-1:0]    s2_c_q;

  // output register
  logic              out_v_q;
  status_e           status_q, status_d;
  logic [UsW-1:0]    fine_q, fine_d, coarse_q, coarse_d;
  logic [UsW-1:0]    f, c, quarter;
  logic              too_far;

  assign adv   = !out_v_q || out_ready_i;
  assign pop_o = adv && !empty_i;

  assign counts = {head_i.wraps, head_i.sub};
  assign x_d    = XW'({10'b0, counts} * {20'b0, FINE_NS_PER_COUNT}) + XW'(FINE_ROUND);
  assign cprod  = {16'b0, head_i.elapsed} * {32'b0, US_PER_TICK};
  assign fprod  = {31'b0, s1_x_q} * {30'b0, RECIP_1000};

  assign f       = UsW'(s2_f_q[RECIP_SHIFT +: FineW]);
  assign c       = s2_c_q;
  assign quarter = c >> 2;
  assign too_far = ((f > c) && ((f - c) > quarter)) || ((c > f) && ((c - f) > quarter));

  always_comb begin
    fine_d   = '0;
    coarse_d = '0;
    unique case (s2_kind_q)
      K_RUNNING: status_d = ST_RUNNING;
      K_IDLE:    status_d = ST_IDLE;
      K_FAIL:    status_d = ST_FAILED;
      K_FINAL: begin
        if (too_far) begin
          status_d = ST_FAILED;
        end else begin
          status_d = ST_OK;
          fine_d   = f;
          coarse_d = c;
        end
      end
      default:   status_d = ST_FAILED;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q  <= !empty_i;
      s2_v_q  <= s1_v_q;
      out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_kind_q <= head_i.kind;
      s1_x_q    <= x_d;
      s1_c_q    <= cprod[UsW-1:0];
      s2_kind_q <= s1_kind_q;
      s2_f_q    <= fprod;
      s2_c_q    <= s1_c_q;
      status_q  <= status_d;
      fine_q    <= fine_d;
      coarse_q  <= coarse_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign status_o    = status_q;
  assign fine_o      = fine_q;
  assign coarse_o    = coarse_q;

endmodule

### rtl/core/dcic_checker.sv
module dcic_checker import dcic_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [63:0]        m_axis_tdata,
  input logic [1:0]         m_axis_tuser
);

  logic [3:0]  pend_q;
  logic        in_acc, out_acc;
  logic [31:0] f, c;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign f       = m_axis_tdata[31:0];
  assign c       = m_axis_tdata[63:32];

  // requests taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 4'd1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 4'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("answer changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 4'd0)
    else $error("answer without a pending request");

  a_zero_unless_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == '0)
    else $error("data fields nonzero without ok status");

  a_ok_within_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_OK |->
      !((f > c) && ((f - c) > (c >> 2))) && !((c > f) && ((c - f) > (c >> 2))))
    else $error("ok reported with clocks diverging beyond a quarter");

endmodule

bind dual_clock_interval_checker_unit dcic_checker u_dcic_checker (.*);
